@@ rtl/mbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbr_pkg: shared definitions for the meter-bus frame receiver
// Frame store geometry, framing bytes, command and status codes, and the
// request word that drives the frame store.
// ----------------------------------------------------------------------------
package mbr_pkg;

  // Frame store geometry
  localparam int unsigned FRAME_MAX = 256;
  localparam int unsigned ADDR_W    = $clog2(FRAME_MAX);
  localparam int unsigned LEN_W     = 9;

  localparam logic [LEN_W-1:0] FRAME_MAX_LEN = LEN_W'(FRAME_MAX);

  // Framing constants
  localparam logic [7:0]       START_BYTE    = 8'h68;
  localparam logic [7:0]       STOP_BYTE     = 8'h16;
  localparam logic [LEN_W-1:0] LEN_FIELD_POS = 9'd10;
  localparam logic [LEN_W-1:0] LEN_EXTRA     = 9'd13;
  localparam logic [15:0]      TIMEOUT_RESET = 16'd1000;

  // Host commands
  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NONE         = 3'd0,
    ST_HUNT_DISCARD = 3'd1,
    ST_STORED       = 3'd2,
    ST_GOOD         = 3'd3,
    ST_BAD          = 3'd4,
    ST_TOO_LONG     = 3'd5,
    ST_TIMEOUT      = 3'd6,
    ST_DROPPED      = 3'd7
  } status_e;

  // Frame store access request
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

@@ rtl/mbr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbr_if: valid/ready channels of the meter-bus frame receiver
// Command channel, result channel and timeout configuration channel.
// ----------------------------------------------------------------------------
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

interface mbr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] read_data;
  logic [8:0] frame_length;
  logic       message_ready;

  modport source (output valid, status, read_data, frame_length, message_ready,
                  input ready);
  modport sink   (input valid, status, read_data, frame_length, message_ready,
                  output ready);
endinterface

interface mbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink   (input valid, timeout_ticks, output ready);
endinterface

@@ rtl/mbr_frame_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbr_frame_store: frame byte memory
// One write port and one read port, read data registered and held until
// the next read.
// ----------------------------------------------------------------------------
module mbr_frame_store (
  input  logic                clk_i,
  input  mbr_pkg::store_req_t req_i,
  output logic [7:0]          rd_data_o
);
  import mbr_pkg::*;

  logic [7:0] mem_q [FRAME_MAX];
  logic [7:0] rd_data_q;

  // Write incoming bytes, register the read word
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/mbus_frame_receiver.sv @@
`timescale 1ns / 1ps
// The result word is registered and appears in the cycle after its command word is accepted.
// Throughput: one command word per cycle while results are taken; the result register frees as it is taken.
// Store reads come from the frame memory's registered read port, alongside their result word.
// Reset: hunting for a start byte, timeout disarmed, timeout_ticks at 1000;
// the frame memory is not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
// mbus_frame_receiver: meter-bus frame receiver
// Hunts for the start byte, stores the frame, checks length, checksum and
// stop byte, runs a tick timeout, and holds a good frame for the host.
// ----------------------------------------------------------------------------
module mbus_frame_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbr_in_if.sink    in_i,
  mbr_cfg_if.sink   cfg_i,
  mbr_out_if.source out_o
);
  import mbr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_HELD   = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] position_q, position_d;
  logic [LEN_W-1:0] expected_q, expected_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       cksum_q, cksum_d;
  logic [15:0]      left_q, left_d;
  logic             armed_q, armed_d;
  logic [15:0]      timeout_ticks_q;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [LEN_W-1:0] frame_length_q;
  logic             msg_ready_q;
  logic             is_read_q, is_read_d;

  logic             in_ready;
  logic             accept;
  cmd_e             cmd;
  store_req_t       store_req;
  logic [7:0]       store_rdata;
  logic [LEN_W-1:0] hdr_len;
  logic [LEN_W:0]   pos_plus1;
  logic [LEN_W:0]   pos_plus2;
  logic [LEN_W:0]   exp_ext;
  logic             rd_in_range;

  // Accept while the result register is empty or being drained
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign cmd        = cmd_e'(in_i.command);
  assign cfg_i.ready = 1'b1;

  assign hdr_len     = LEN_W'(in_i.rx_byte) + LEN_EXTRA;
  assign pos_plus1   = {1'b0, position_q} + 10'd1;
  assign pos_plus2   = {1'b0, position_q} + 10'd2;
  assign exp_ext     = {1'b0, expected_q};
  assign rd_in_range = LEN_W'(in_i.read_index) < FRAME_MAX_LEN;

  // Next-state logic for one command word
  always_comb begin
    phase_d    = phase_q;
    position_d = position_q;
    expected_d = expected_q;
    sum_d      = sum_q;
    cksum_d    = cksum_q;
    left_d     = left_q;
    armed_d    = armed_q;
    status_d   = ST_NONE;
    is_read_d  = 1'b0;
    store_req  = '0;

    if (accept) begin
      unique case (cmd)
        CMD_BYTE: begin
          unique case (phase_q)
            PH_HUNT: begin
              if (in_i.rx_byte != START_BYTE) begin
                status_d = ST_HUNT_DISCARD;
              end else begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = '0;
                store_req.wr_data = in_i.rx_byte;
                position_d = 9'd1;
                sum_d      = in_i.rx_byte;
                expected_d = '0;
                left_d     = timeout_ticks_q;
                armed_d    = 1'b1;
                phase_d    = PH_HEADER;
                status_d   = ST_STORED;
              end
            end
            PH_HEADER: begin
              store_req.wr_en   = 1'b1;
              store_req.wr_addr = position_q[ADDR_W-1:0];
              store_req.wr_data = in_i.rx_byte;
              sum_d      = sum_q + in_i.rx_byte;
              position_d = position_q + 9'd1;
              status_d   = ST_STORED;
              // Length byte: set the frame length, drop oversize frames
              if (position_q == LEN_FIELD_POS) begin
                expected_d = hdr_len;
                if (hdr_len > FRAME_MAX_LEN) begin
                  phase_d  = PH_HUNT;
                  armed_d  = 1'b0;
                  status_d = ST_TOO_LONG;
                end else begin
                  phase_d = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              store_req.wr_en   = 1'b1;
              store_req.wr_addr = position_q[ADDR_W-1:0];
              store_req.wr_data = in_i.rx_byte;
              position_d = position_q + 9'd1;
              status_d   = ST_STORED;
              if (pos_plus2 < exp_ext) begin
                sum_d = sum_q + in_i.rx_byte;
              end
              // Capture the checksum byte as it passes
              if (pos_plus2 == exp_ext) begin
                cksum_d = in_i.rx_byte;
              end
              // Last byte: check stop byte and checksum; byte 0 is always the start byte
              if (pos_plus1 >= exp_ext) begin
                armed_d = 1'b0;
                if (in_i.rx_byte == STOP_BYTE && cksum_q == sum_q) begin
                  phase_d  = PH_HELD;
                  status_d = ST_GOOD;
                end else begin
                  phase_d  = PH_HUNT;
                  status_d = ST_BAD;
                end
              end
            end
            PH_HELD: begin
              status_d = ST_DROPPED;
            end
            default: begin
              status_d = ST_NONE;
            end
          endcase
        end
        CMD_TICK: begin
          if (armed_q) begin
            if (left_q <= 16'd1) begin
              left_d     = '0;
              armed_d    = 1'b0;
              phase_d    = PH_HUNT;
              expected_d = '0;
              status_d   = ST_TIMEOUT;
            end else begin
              left_d = left_q - 16'd1;
            end
          end
        end
        CMD_RELEASE: begin
          if (phase_q == PH_HELD) begin
            phase_d    = PH_HUNT;
            expected_d = '0;
          end
        end
        CMD_READ: begin
          store_req.rd_en   = rd_in_range;
          store_req.rd_addr = ADDR_W'(in_i.read_index);
          is_read_d         = rd_in_range;
        end
        default: begin
          status_d = ST_NONE;
        end
      endcase
    end
  end

  // Hold receiver state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HUNT;
      position_q      <= '0;
      expected_q      <= '0;
      sum_q           <= '0;
      cksum_q         <= '0;
      left_q          <= '0;
      armed_q         <= 1'b0;
      timeout_ticks_q <= TIMEOUT_RESET;
      out_valid_q     <= 1'b0;
      status_q        <= ST_NONE;
      frame_length_q  <= '0;
      msg_ready_q     <= 1'b0;
      is_read_q       <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      position_q <= position_d;
      expected_q <= expected_d;
      sum_q      <= sum_d;
      cksum_q    <= cksum_d;
      left_q     <= left_d;
      armed_q    <= armed_d;
      if (cfg_i.valid) begin
        timeout_ticks_q <= cfg_i.timeout_ticks;
      end
      if (accept) begin
        out_valid_q    <= 1'b1;
        status_q       <= status_d;
        frame_length_q <= expected_d;
        msg_ready_q    <= (phase_d == PH_HELD);
        is_read_q      <= is_read_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  mbr_frame_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (store_rdata)
  );

  // Drive the result word
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.read_data     = is_read_q ? store_rdata : 8'd0;
  assign out_o.frame_length  = frame_length_q;
  assign out_o.message_ready = msg_ready_q;

  // A held frame never has a running timeout
  a_held_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HELD |-> !armed_q)
    else $error("timeout armed while a frame is held");

  // A pending result blocks the command side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("command taken while result stalled");

  // A store read yields a result with no status next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CMD_READ |=> out_valid_q && status_q == ST_NONE)
    else $error("store read result missing");

  // Data phase stays inside the expected frame
  a_data_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> position_q < expected_q && expected_q <= FRAME_MAX_LEN)
    else $error("data position beyond frame length");

endmodule
